// ===== rtl/taqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taqe_pkg: shared types and constants of the tree ancestor query engine
// Node and level widths, function codes, controller states and the
// request bundles that the controller sends to the two table memories.
// ----------------------------------------------------------------------------
package taqe_pkg;

  // Node numbers and jump levels.
  localparam int NODE_W      = 16;
  localparam int LOG_LEVELS  = 16;
  localparam int LEVEL_W     = 4;
  localparam int JUMP_ADDR_W = NODE_W + LEVEL_W;
  localparam int DIST_W      = NODE_W + 1;
  localparam int FUNC_W      = 2;

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [JUMP_ADDR_W-1:0] jump_addr_t;
  typedef logic [DIST_W-1:0]      dist_t;

  localparam level_t LEVEL_FIRST = '0;
  localparam level_t LEVEL_LAST  = LEVEL_W'(LOG_LEVELS - 1);
  localparam node_t  NODE_NULL   = '0;
  localparam node_t  DEPTH_MAX   = '1;

  // Function codes of an input item.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LCA    = 2'd1,
    FUNC_KTH    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_LCA_D1,
    ST_LCA_D2,
    ST_CLIMB,
    ST_LCA_A,
    ST_LCA_B,
    ST_LCA_LAST,
    ST_LCA_PAR,
    ST_LCA_DC
  } state_t;

  // Request bundle for the depth table.
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    node_t wr_data;
  } depth_req_t;

  // Request bundle for the jump table; an address is {node, level}.
  typedef struct packed {
    logic       rd_en;
    jump_addr_t rd_addr;
    logic       wr_en;
    jump_addr_t wr_addr;
    node_t      wr_data;
  } jump_req_t;

endpackage

// ===== rtl/taqe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taqe_ram: single-write, single-read synchronous table memory
// Read data is registered. A read of the same entry that is written in
// that cycle returns the new data, and every entry of row zero reads as
// zero, whatever was written to it.
// ----------------------------------------------------------------------------
module taqe_ram #(
  parameter int ADDR_W  = 16,
  parameter int DATA_W  = 16,
  parameter int ROW_LSB = 0
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] wr_q;
  logic              fwd_q;
  logic              zero_q;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with same-cycle write forwarding and the null row.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      wr_q   <= wr_data;
      fwd_q  <= wr_en && (wr_addr == rd_addr);
      zero_q <= (rd_addr[ADDR_W-1:ROW_LSB] == '0);
    end
  end

  assign rd_data = zero_q ? '0 : (fwd_q ? wr_q : mem_q);

endmodule

// ===== rtl/taqe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taqe_ctrl: sequencer of the tree ancestor query engine
// Runs inserts, k-th ancestor climbs and common ancestor searches as
// chains of reads of the depth and jump tables, at most one jump read per cycle.
// ----------------------------------------------------------------------------
module taqe_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [taqe_pkg::FUNC_W-1:0]   func,
  input  taqe_pkg::node_t               node_a,
  input  taqe_pkg::node_t               node_b,
  input  taqe_pkg::node_t               steps,
  output logic                          busy,
  output logic                          done,
  output taqe_pkg::node_t               ancestor,
  output taqe_pkg::dist_t               distance,
  output taqe_pkg::depth_req_t          depth_req,
  input  taqe_pkg::node_t               depth_rd_data,
  output taqe_pkg::jump_req_t           jump_req,
  input  taqe_pkg::node_t               jump_rd_data
);

  import taqe_pkg::*;

  state_t state, state_next;
  node_t  a_reg, a_reg_next;
  node_t  b_reg, b_reg_next;
  node_t  mask, mask_next;
  node_t  pa, pa_next;
  node_t  dhi, dhi_next;
  node_t  dlo, dlo_next;
  node_t  ins_depth, ins_depth_next;
  level_t lvl, lvl_next;
  logic   rd_live, rd_live_next;
  logic   climb_kth, climb_kth_next;
  logic   done_next;
  node_t  ancestor_next;
  dist_t  distance_next;

  node_t  u_cur;
  node_t  a_cur;
  node_t  b_cur;
  node_t  depth_inc;
  logic   cmp_hit;

  // Index of the lowest set bit of a nonzero climb mask.
  function automatic level_t low_bit(input node_t m);
    level_t idx;
    idx = '0;
    for (int i = LOG_LEVELS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = LEVEL_W'(i);
      end
    end
    return idx;
  endfunction

  // The node being climbed is the fresh read data once a read is in flight.
  assign u_cur = rd_live ? jump_rd_data : a_reg;

  // Common ancestor step: move both nodes up when their ancestors differ.
  assign cmp_hit = rd_live && (pa != jump_rd_data);
  assign a_cur   = cmp_hit ? pa : a_reg;
  assign b_cur   = cmp_hit ? jump_rd_data : b_reg;

  // Depth of a new node saturates at the top of the range.
  assign depth_inc = (depth_rd_data == DEPTH_MAX) ? DEPTH_MAX : depth_rd_data + 1'b1;

  assign busy = (state != ST_IDLE);

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    a_reg     <= a_reg_next;
    b_reg     <= b_reg_next;
    mask      <= mask_next;
    pa        <= pa_next;
    dhi       <= dhi_next;
    dlo       <= dlo_next;
    ins_depth <= ins_depth_next;
    lvl       <= lvl_next;
    rd_live   <= rd_live_next;
    climb_kth <= climb_kth_next;
    ancestor  <= ancestor_next;
    distance  <= distance_next;
  end

  // Next state, memory requests and results.
  always_comb begin
    state_next     = state;
    a_reg_next     = a_reg;
    b_reg_next     = b_reg;
    mask_next      = mask;
    pa_next        = pa;
    dhi_next       = dhi;
    dlo_next       = dlo;
    ins_depth_next = ins_depth;
    lvl_next       = lvl;
    rd_live_next   = rd_live;
    climb_kth_next = climb_kth;
    done_next      = 1'b0;
    ancestor_next  = ancestor;
    distance_next  = distance;
    depth_req      = '0;
    jump_req       = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          a_reg_next   = node_a;
          b_reg_next   = node_b;
          rd_live_next = 1'b0;
          case (func_t'(func))
            FUNC_INSERT: begin
              if (node_a == NODE_NULL) begin
                // Inserting the null node is ignored.
                done_next     = 1'b1;
                ancestor_next = '0;
                distance_next = '0;
              end else begin
                // Parent depth, first jump entry, and the parent's first jump.
                depth_req.rd_en   = 1'b1;
                depth_req.rd_addr = node_b;
                jump_req.wr_en    = 1'b1;
                jump_req.wr_addr  = {node_a, LEVEL_FIRST};
                jump_req.wr_data  = node_b;
                jump_req.rd_en    = 1'b1;
                jump_req.rd_addr  = {node_b, LEVEL_FIRST};
                lvl_next          = LEVEL_FIRST + 1'b1;
                state_next        = ST_INS;
              end
            end
            FUNC_LCA: begin
              depth_req.rd_en   = 1'b1;
              depth_req.rd_addr = node_a;
              state_next        = ST_LCA_D1;
            end
            FUNC_KTH: begin
              mask_next      = steps;
              climb_kth_next = 1'b1;
              state_next     = ST_CLIMB;
            end
            default: begin
              done_next     = 1'b1;
              ancestor_next = '0;
              distance_next = '0;
            end
          endcase
        end
      end

      ST_INS: begin
        // Store the 2^lvl-th ancestor and fetch the next one through it.
        jump_req.wr_en   = 1'b1;
        jump_req.wr_addr = {a_reg, lvl};
        jump_req.wr_data = jump_rd_data;
        if (lvl == LEVEL_FIRST + 1'b1) begin
          depth_req.wr_en   = 1'b1;
          depth_req.wr_addr = a_reg;
          depth_req.wr_data = depth_inc;
          ins_depth_next    = depth_inc;
        end
        if (lvl == LEVEL_LAST) begin
          done_next     = 1'b1;
          ancestor_next = a_reg;
          distance_next = {1'b0, ins_depth};
          state_next    = ST_IDLE;
        end else begin
          jump_req.rd_en   = 1'b1;
          jump_req.rd_addr = {jump_rd_data, lvl};
          lvl_next         = lvl + 1'b1;
        end
      end

      ST_LCA_D1: begin
        dhi_next          = depth_rd_data;
        depth_req.rd_en   = 1'b1;
        depth_req.rd_addr = b_reg;
        state_next        = ST_LCA_D2;
      end

      ST_LCA_D2: begin
        // Put the deeper node in a_reg and climb it by the depth gap.
        if (dhi < depth_rd_data) begin
          a_reg_next = b_reg;
          b_reg_next = a_reg;
          dhi_next   = depth_rd_data;
          dlo_next   = dhi;
          mask_next  = depth_rd_data - dhi;
        end else begin
          dlo_next  = depth_rd_data;
          mask_next = dhi - depth_rd_data;
        end
        climb_kth_next = 1'b0;
        rd_live_next   = 1'b0;
        state_next     = ST_CLIMB;
      end

      ST_CLIMB: begin
        if (mask == '0) begin
          if (climb_kth) begin
            done_next     = 1'b1;
            ancestor_next = u_cur;
            distance_next = '0;
            state_next    = ST_IDLE;
          end else if (u_cur == b_reg) begin
            // The shallower node is itself the common ancestor.
            done_next     = 1'b1;
            ancestor_next = u_cur;
            distance_next = {1'b0, dhi - dlo};
            state_next    = ST_IDLE;
          end else begin
            a_reg_next   = u_cur;
            rd_live_next = 1'b0;
            lvl_next     = LEVEL_LAST;
            state_next   = ST_LCA_A;
          end
        end else begin
          // One jump per set bit of the remaining step count.
          jump_req.rd_en   = 1'b1;
          jump_req.rd_addr = {u_cur, low_bit(mask)};
          mask_next        = mask & (mask - 1'b1);
          a_reg_next       = u_cur;
          rd_live_next     = 1'b1;
        end
      end

      ST_LCA_A: begin
        // Settle the previous level, then fetch the first node's ancestor.
        a_reg_next       = a_cur;
        b_reg_next       = b_cur;
        jump_req.rd_en   = 1'b1;
        jump_req.rd_addr = {a_cur, lvl};
        rd_live_next     = 1'b0;
        state_next       = ST_LCA_B;
      end

      ST_LCA_B: begin
        pa_next          = jump_rd_data;
        jump_req.rd_en   = 1'b1;
        jump_req.rd_addr = {b_reg, lvl};
        rd_live_next     = 1'b1;
        if (lvl == LEVEL_FIRST) begin
          state_next = ST_LCA_LAST;
        end else begin
          lvl_next   = lvl - 1'b1;
          state_next = ST_LCA_A;
        end
      end

      ST_LCA_LAST: begin
        // The parent of the settled first node is the common ancestor.
        jump_req.rd_en   = 1'b1;
        jump_req.rd_addr = {a_cur, LEVEL_FIRST};
        rd_live_next     = 1'b0;
        state_next       = ST_LCA_PAR;
      end

      ST_LCA_PAR: begin
        a_reg_next        = jump_rd_data;
        depth_req.rd_en   = 1'b1;
        depth_req.rd_addr = jump_rd_data;
        state_next        = ST_LCA_DC;
      end

      ST_LCA_DC: begin
        done_next     = 1'b1;
        ancestor_next = a_reg;
        distance_next = {1'b0, dhi} + {1'b0, dlo} - {depth_rd_data, 1'b0};
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tree_ancestor_query_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_top: binary-lifting common ancestor engine
// Holds node depths and 2^j-th ancestor rows in two synchronous tables and
// answers inserts, common ancestor / distance queries and k-th ancestors.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Payload
//  -------   ---------------   ---------------------------------------
//  command   start, busy       func, node_a, node_b, steps
//  result    done (strobe)     ancestor, distance
//
// One command is in work at a time; the jump table has one read port and
// every jump read depends on the one before it.
// Insert writes one jump row entry a cycle. Null insert and the unused code
// answer at once. A k-th ancestor climb takes one jump read per set bit of
// steps. A common ancestor search climbs the deeper node one jump read per
// set bit of the depth gap; unless the shallower node is the answer, it then
// makes two jump reads per level over 16 levels.
// No clearing pass after reset: row zero of both tables reads as zero.
// The result strobe lasts one cycle and cannot be held off by the receiver.
//
module tree_ancestor_query_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [taqe_pkg::FUNC_W-1:0]   func,
  input  logic [taqe_pkg::NODE_W-1:0]   node_a,
  input  logic [taqe_pkg::NODE_W-1:0]   node_b,
  input  logic [taqe_pkg::NODE_W-1:0]   steps,
  output logic                          done,
  output logic [taqe_pkg::NODE_W-1:0]   ancestor,
  output logic [taqe_pkg::DIST_W-1:0]   distance
);

  import taqe_pkg::*;

  depth_req_t depth_req;
  jump_req_t  jump_req;
  node_t      depth_rd_data;
  node_t      jump_rd_data;

  // Sequencer.
  taqe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (func),
    .node_a        (node_a),
    .node_b        (node_b),
    .steps         (steps),
    .busy          (busy),
    .done          (done),
    .ancestor      (ancestor),
    .distance      (distance),
    .depth_req     (depth_req),
    .depth_rd_data (depth_rd_data),
    .jump_req      (jump_req),
    .jump_rd_data  (jump_rd_data)
  );

  // Depth table, one entry per node.
  taqe_ram #(
    .ADDR_W  (NODE_W),
    .DATA_W  (NODE_W),
    .ROW_LSB (0)
  ) u_depth_ram (
    .clk     (clk),
    .rd_en   (depth_req.rd_en),
    .rd_addr (depth_req.rd_addr),
    .rd_data (depth_rd_data),
    .wr_en   (depth_req.wr_en),
    .wr_addr (depth_req.wr_addr),
    .wr_data (depth_req.wr_data)
  );

  // Jump table, one row of LOG_LEVELS ancestors per node.
  taqe_ram #(
    .ADDR_W  (JUMP_ADDR_W),
    .DATA_W  (NODE_W),
    .ROW_LSB (LEVEL_W)
  ) u_jump_ram (
    .clk     (clk),
    .rd_en   (jump_req.rd_en),
    .rd_addr (jump_req.rd_addr),
    .rd_data (jump_rd_data),
    .wr_en   (jump_req.wr_en),
    .wr_addr (jump_req.wr_addr),
    .wr_data (jump_req.wr_data)
  );

  // A result always leaves the engine ready for the next command.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the engine is still busy");

  // A transferred command either starts work or finishes at once.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("command transfer was dropped");

  // The unused function code answers at once with an empty result.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_NONE) |=> (done && ancestor == '0 && distance == '0))
    else $error("unused function code did not give an empty result");

  // The depth table is never written while the engine is idle.
  assert property (@(posedge clk) disable iff (rst)
    !busy |-> !depth_req.wr_en || $past(start))
    else $error("depth table written while idle");

endmodule
